// File: rtl/ldla_pkg.sv
// Package for the Lambertian diffuse light accumulator.
// Holds the transaction types, the sequencer state type and the shared constants.
// Depends on nothing else.
`timescale 1ns / 1ps

package ldla_pkg;

	typedef struct packed {
		logic signed [31:0] light_x;
		logic signed [31:0] light_y;
		logic signed [31:0] light_z;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic        [47:0] light_rgb;
		logic        [47:0] diffuse_rgb;
		logic               last_light;
	} ray_t;

	typedef struct packed {
		logic [15:0] red_sum;
		logic [15:0] green_sum;
		logic [15:0] blue_sum;
		logic        clipped;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NORM,
		S_MUL,
		S_CHK,
		S_SQRT,
		S_DIV,
		S_COLOR,
		S_FIN
	} state_t;

	localparam int COLOR_FRAC_BITS_DEF = 14;
	localparam logic [15:0] COS_ONE   = 16'd16384;
	localparam logic [15:0] SUM_MAX   = 16'hFFFF;
	localparam logic [4:0]  SQRT_TOP  = 5'd20;
	localparam logic [4:0]  DIV_TOP   = 5'd15;
	localparam logic [2:0]  STEP_LAST = 3'd6;
	localparam logic [2:0]  DOT_FIRST = 3'd3;

endpackage

// File: rtl/lambert_diffuse_light_accumulator.sv
// Lambertian diffuse light accumulator, top level and only module.
// Depends on ldla_pkg for the transaction types, the state type and constants.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// ray       in         ray_valid/ray_stall  ldla_pkg::ray_t, one light ray per transaction
// px        out        px_valid/px_stall    ldla_pkg::result_t, one per ray marked last
//
// One ray passes through these steps in order: accepting it, normalising the
// hit-to-light vector a bit a step, the squares and dot products, a test of the
// sign of the dot product, the square root, the division, colouring and the
// finish; a single 32 x 16 multiplier and a single 42-bit compare and subtract
// are shared among these steps.
// A ray with the light on the hit point goes straight to the finish, and a ray whose
// cosine is not positive skips the root, division and colouring.
// Reset clears the channel sums, the clip flag and the output valid flag at once.
// A stalled result holds; the next ray is still taken, and only a second last ray
// waits in its final cycle until the pending result transaction completes.
module lambert_diffuse_light_accumulator #(
	parameter int COLOR_FRAC_BITS = ldla_pkg::COLOR_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ray_valid,
	output logic              ray_stall,
	input  ldla_pkg::ray_t    ray,
	output logic              px_valid,
	input  logic              px_stall,
	output ldla_pkg::result_t px
);

	// Shift that brings the product of the two colours and the cosine back to COLOR_FRAC_BITS fraction bits.
	localparam int PROD_SHIFT = COLOR_FRAC_BITS + 14;

	ldla_pkg::state_t state_q, state_next;

	// Latched ray: sign and magnitude of the hit-to-light vector and of the normal.
	logic [32:0] mag_q  [3];
	logic        neg_q  [3];
	logic [15:0] nmag_q [3];
	logic        nneg_q [3];
	logic [47:0] light_q;
	logic [47:0] diff_q;
	logic        last_q;

	logic [2:0]         step_q;
	logic [4:0]         k_q;
	logic [33:0]        len2_q;
	logic signed [35:0] dot_q;
	logic [41:0]        x_q;
	logic [41:0]        res_q;
	logic [20:0]        lenq_q;
	logic [15:0]        q_q;
	logic [15:0]        cos_q;
	logic [47:0]        prod_q;
	logic [15:0]        sums_q [3];
	logic               clip_q;
	logic               px_valid_q;
	ldla_pkg::result_t  px_q;

	// Shared multiplier and shared compare and subtract unit.
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic [47:0] mul_p;
	logic [41:0] sub_b;
	logic        sub_ge;
	logic [41:0] sub_d;

	logic        ray_take;
	logic        vec_zero, vec_hi, vec_lo, dot_pos, out_busy;
	logic [41:0] bitv;
	logic [41:0] res_next;
	logic [15:0] q_next;
	logic [2:0]  acc_idx;
	logic [1:0]  col_acc;
	logic [47:0] sum_wide;

	assign ray_take = ray_valid && !ray_stall;
	assign vec_zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
	assign vec_hi   = (mag_q[0][32:16] != '0) || (mag_q[1][32:16] != '0)
		|| (mag_q[2][32:16] != '0);
	assign vec_lo   = (mag_q[0][32:15] == '0) && (mag_q[1][32:15] == '0)
		&& (mag_q[2][32:15] == '0);
	assign dot_pos  = !dot_q[35] && (dot_q != '0);
	assign out_busy = px_valid_q && px_stall;

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ldla_pkg::S_IDLE: begin
				if (ray_take) begin
					state_next = ldla_pkg::S_NORM;
				end
			end
			ldla_pkg::S_NORM: begin
				if (vec_zero) begin
					state_next = ldla_pkg::S_FIN;
				end else if (!vec_hi && !vec_lo) begin
					state_next = ldla_pkg::S_MUL;
				end
			end
			ldla_pkg::S_MUL: begin
				if (step_q == ldla_pkg::STEP_LAST) begin
					state_next = ldla_pkg::S_CHK;
				end
			end
			ldla_pkg::S_CHK: begin
				state_next = dot_pos ? ldla_pkg::S_SQRT : ldla_pkg::S_FIN;
			end
			ldla_pkg::S_SQRT: begin
				if (k_q == '0) begin
					state_next = ldla_pkg::S_DIV;
				end
			end
			ldla_pkg::S_DIV: begin
				if (k_q == '0) begin
					state_next = ldla_pkg::S_COLOR;
				end
			end
			ldla_pkg::S_COLOR: begin
				if (step_q == ldla_pkg::STEP_LAST) begin
					state_next = ldla_pkg::S_FIN;
				end
			end
			ldla_pkg::S_FIN: begin
				if (!(last_q && out_busy)) begin
					state_next = ldla_pkg::S_IDLE;
				end
			end
			default: state_next = ldla_pkg::S_IDLE;
		endcase
	end

	// Operand selection for the shared units.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sub_b = '0;
		case (state_q)
			ldla_pkg::S_MUL: begin
				if (step_q < ldla_pkg::DOT_FIRST) begin
					mul_a = {16'd0, mag_q[step_q[1:0]][15:0]};
					mul_b = mag_q[step_q[1:0]][15:0];
				end else if (step_q < ldla_pkg::STEP_LAST) begin
					mul_a = {16'd0, mag_q[2'(step_q - ldla_pkg::DOT_FIRST)][15:0]};
					mul_b = nmag_q[2'(step_q - ldla_pkg::DOT_FIRST)];
				end
			end
			ldla_pkg::S_COLOR: begin
				if (step_q[0]) begin
					mul_a = prod_q[31:0];
					mul_b = cos_q;
				end else if (step_q < ldla_pkg::STEP_LAST) begin
					mul_a = {16'd0, light_q[6'd47 - {step_q[2:1], 4'd0} -: 16]};
					mul_b = diff_q[6'd47 - {step_q[2:1], 4'd0} -: 16];
				end
			end
			ldla_pkg::S_SQRT: sub_b = res_q + bitv;
			ldla_pkg::S_DIV:  sub_b = 42'(lenq_q) << k_q[3:0];
			default: ;
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign sub_ge = x_q >= sub_b;
	assign sub_d  = x_q - sub_b;
	assign bitv   = 42'(1) << {k_q, 1'b0};

	always_comb begin
		res_next = sub_ge ? ((res_q >> 1) + bitv) : (res_q >> 1);
		q_next   = q_q;
		q_next[k_q[3:0]] = sub_ge;
	end

	assign acc_idx  = step_q - 3'd1;
	assign col_acc  = 2'(step_q[2:1] - 2'd1);
	assign sum_wide = 48'(sums_q[col_acc]) + (prod_q >> PROD_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ldla_pkg::S_IDLE;
			sums_q[0]  <= '0;
			sums_q[1]  <= '0;
			sums_q[2]  <= '0;
			clip_q     <= 1'b0;
			px_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ldla_pkg::S_COLOR && !step_q[0] && step_q != '0) begin
				if (sum_wide > 48'(ldla_pkg::SUM_MAX)) begin
					sums_q[col_acc] <= ldla_pkg::SUM_MAX;
					clip_q          <= 1'b1;
				end else begin
					sums_q[col_acc] <= sum_wide[15:0];
				end
			end
			if (state_q == ldla_pkg::S_FIN && last_q && !out_busy) begin
				px_valid_q <= 1'b1;
				sums_q[0]  <= '0;
				sums_q[1]  <= '0;
				sums_q[2]  <= '0;
				clip_q     <= 1'b0;
			end else if (px_valid_q && !px_stall) begin
				px_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			ldla_pkg::S_IDLE: begin
				if (ray_take) begin
					logic signed [32:0] d [3];
					d[0] = 33'($signed(ray.light_x)) - 33'($signed(ray.hit_x));
					d[1] = 33'($signed(ray.light_y)) - 33'($signed(ray.hit_y));
					d[2] = 33'($signed(ray.light_z)) - 33'($signed(ray.hit_z));
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= d[i][32];
						mag_q[i] <= d[i][32] ? 33'(-d[i]) : d[i];
					end
					nneg_q[0] <= ray.normal_x[15];
					nneg_q[1] <= ray.normal_y[15];
					nneg_q[2] <= ray.normal_z[15];
					nmag_q[0] <= ray.normal_x[15] ? 16'(-ray.normal_x) : ray.normal_x;
					nmag_q[1] <= ray.normal_y[15] ? 16'(-ray.normal_y) : ray.normal_y;
					nmag_q[2] <= ray.normal_z[15] ? 16'(-ray.normal_z) : ray.normal_z;
					light_q <= ray.light_rgb;
					diff_q  <= ray.diffuse_rgb;
					last_q  <= ray.last_light;
				end
			end
			ldla_pkg::S_NORM: begin
				// Truncating one bit at a time equals one truncating shift.
				for (int i = 0; i < 3; i++) begin
					if (vec_hi) begin
						mag_q[i] <= mag_q[i] >> 1;
					end else if (vec_lo) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
				step_q <= '0;
				len2_q <= '0;
				dot_q  <= '0;
			end
			ldla_pkg::S_MUL: begin
				step_q <= step_q + 3'd1;
				if (step_q != '0) begin
					if (acc_idx < ldla_pkg::DOT_FIRST) begin
						len2_q <= len2_q + prod_q[33:0];
					end else if (neg_q[2'(acc_idx - ldla_pkg::DOT_FIRST)]
						^ nneg_q[2'(acc_idx - ldla_pkg::DOT_FIRST)]) begin
						dot_q <= dot_q - $signed({4'd0, prod_q[31:0]});
					end else begin
						dot_q <= dot_q + $signed({4'd0, prod_q[31:0]});
					end
				end
			end
			ldla_pkg::S_CHK: begin
				x_q   <= {len2_q, 8'd0};
				res_q <= '0;
				k_q   <= ldla_pkg::SQRT_TOP;
			end
			ldla_pkg::S_SQRT: begin
				res_q <= res_next;
				if (k_q == '0) begin
					lenq_q <= res_next[20:0];
					x_q    <= 42'(dot_q[34:0]) << 4;
					q_q    <= '0;
					k_q    <= ldla_pkg::DIV_TOP;
				end else begin
					if (sub_ge) begin
						x_q <= sub_d;
					end
					k_q <= k_q - 5'd1;
				end
			end
			ldla_pkg::S_DIV: begin
				q_q <= q_next;
				if (sub_ge) begin
					x_q <= sub_d;
				end
				k_q <= k_q - 5'd1;
				cos_q  <= (q_next > ldla_pkg::COS_ONE) ? ldla_pkg::COS_ONE : q_next;
				step_q <= '0;
			end
			ldla_pkg::S_COLOR: step_q <= step_q + 3'd1;
			ldla_pkg::S_FIN: begin
				if (last_q && !out_busy) begin
					px_q.red_sum   <= sums_q[0];
					px_q.green_sum <= sums_q[1];
					px_q.blue_sum  <= sums_q[2];
					px_q.clipped   <= clip_q;
				end
			end
			default: ;
		endcase
	end

	assign ray_stall = state_q != ldla_pkg::S_IDLE;
	assign px_valid  = px_valid_q;
	assign px        = px_q;

	// A result only appears from the final cycle of a ray marked last.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(px_valid_q) |-> $past(state_q == ldla_pkg::S_FIN && last_q))
		else $error("result raised outside the final step of a last ray");

	// Emitting a result clears the accumulators.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(px_valid_q) |-> (sums_q[0] == '0 && sums_q[1] == '0
			&& sums_q[2] == '0 && !clip_q))
		else $error("accumulators not cleared after a result");

	// The cosine used for colouring never exceeds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ldla_pkg::S_COLOR |-> cos_q <= ldla_pkg::COS_ONE)
		else $error("cosine above one");

	// Division never starts with a bit index beyond the quotient width.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ldla_pkg::S_DIV |-> k_q <= ldla_pkg::DIV_TOP)
		else $error("division bit index out of range");

	// Normalisation leaves every magnitude within sixteen bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ldla_pkg::S_MUL |-> !vec_hi)
		else $error("vector not normalised before the products");

endmodule
